// ===== src/mbam_pkg.sv =====
package mbam_pkg;

  localparam int PHYS_BITS_DEF   = 28;
  localparam int BLOCK_COUNT_DEF = 8;
  localparam int OUT_BITS        = 28;
  localparam int ADDR_BITS       = 16;
  // working width for address sums: wide enough for PHYS_BITS up to 32 plus a carry
  localparam int CALC_BITS       = 33;

  localparam logic [2:0] OP_READ     = 3'd0;
  localparam logic [2:0] OP_WRITE    = 3'd1;
  localparam logic [2:0] OP_MAP      = 3'd2;
  localparam logic [2:0] OP_EOM      = 3'd3;
  localparam logic [2:0] OP_BANK_SET = 3'd4;
  localparam logic [2:0] OP_BANK_OFF = 3'd5;
  localparam logic [2:0] OP_BANK_BASE = 3'd6;

  localparam logic [1:0] TGT_MEM  = 2'd0;
  localparam logic [1:0] TGT_IO   = 2'd1;
  localparam logic [1:0] TGT_DROP = 2'd2;
  localparam logic [1:0] TGT_NONE = 2'd3;

  localparam logic [0:0] CFG_ROM_START = 1'b0;
  localparam logic [0:0] CFG_ROM_BASE  = 1'b1;

  localparam logic [16:0] ROM_START_RST = 17'h0E000;
  localparam logic [3:0]  IO_PAGE_NIB   = 4'hD;
  localparam logic [7:0]  STUB_PAGE     = 8'hFF;
  localparam int          IO_BLOCK      = 6;
  localparam logic [7:0]  MAP_MB_KEY    = 8'h0F;

  typedef struct packed {
    logic [7:0]  low_mb;
    logic [7:0]  high_mb;
    logic [11:0] low_off;
    logic [11:0] high_off;
    logic [7:0]  blk_mask;
  } map_state_t;

endpackage

// ===== src/mbam_xlate.sv =====
module mbam_xlate
  import mbam_pkg::*;
#(
  parameter int PHYS_BITS   = PHYS_BITS_DEF,
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF
) (
  input  logic [2:0]             op_i,
  input  logic [ADDR_BITS-1:0]   addr_i,
  input  logic [7:0]             wr_data_i,
  input  map_state_t             map_st_i,
  input  logic [BLOCK_COUNT-1:0] bank_en_i,
  input  logic [PHYS_BITS-1:0]   blk_base_i,
  input  logic [16:0]            rom_start_i,
  input  logic [OUT_BITS-1:0]    rom_base_i,
  output logic [OUT_BITS-1:0]    phys_o,
  output logic [1:0]             target_o,
  output logic [7:0]             dout_o
);

  localparam int BLK_BITS = $clog2(BLOCK_COUNT);
  localparam logic [CALC_BITS-1:0] PMask =
    (CALC_BITS'(1) << PHYS_BITS) - CALC_BITS'(1);

  logic [BLK_BITS-1:0]  blk;
  logic                 owned, io_hit, above_rom, stub;
  logic [CALC_BITS-1:0] rom_phys, bank_phys, map_phys, own_phys, phys;
  logic [11:0]          off;
  logic [7:0]           mb;
  logic [19:0]          map_sum;

  assign blk       = addr_i[ADDR_BITS-1 -: BLK_BITS];
  assign owned     = bank_en_i[blk] | map_st_i.blk_mask[blk];
  assign io_hit    = (addr_i[15:12] == IO_PAGE_NIB) && (!owned || bank_en_i[IO_BLOCK]);
  assign above_rom = {1'b0, addr_i} >= rom_start_i;
  assign stub      = addr_i[15:8] == STUB_PAGE;

  assign off     = addr_i[15] ? map_st_i.high_off : map_st_i.low_off;
  assign mb      = addr_i[15] ? map_st_i.high_mb : map_st_i.low_mb;
  // offset add wraps inside the selected megabyte
  assign map_sum = {off, 8'h00} + {4'h0, addr_i};

  assign rom_phys  = (CALC_BITS'(rom_base_i) + CALC_BITS'(addr_i)) & PMask;
  assign bank_phys = (CALC_BITS'(blk_base_i) + CALC_BITS'(addr_i[12:0])) & PMask;
  assign map_phys  = (CALC_BITS'({mb, 20'h00000}) + CALC_BITS'(map_sum)) & PMask;
  assign own_phys  = stub ? rom_phys : (bank_en_i[blk] ? bank_phys : map_phys);

  always_comb begin
    phys     = '0;
    target_o = TGT_NONE;
    dout_o   = 8'h00;
    case (op_i)
      OP_READ: begin
        if (io_hit) begin
          phys     = CALC_BITS'(addr_i);
          target_o = TGT_IO;
        end else if (!owned) begin
          phys     = above_rom ? rom_phys : CALC_BITS'(addr_i);
          target_o = TGT_MEM;
        end else begin
          phys     = own_phys;
          target_o = TGT_MEM;
        end
      end
      OP_WRITE: begin
        if (io_hit) begin
          phys     = CALC_BITS'(addr_i);
          target_o = TGT_IO;
          dout_o   = wr_data_i;
        end else if (!owned) begin
          if (above_rom) begin
            target_o = TGT_DROP;
          end else begin
            phys     = CALC_BITS'(addr_i);
            target_o = TGT_MEM;
            dout_o   = wr_data_i;
          end
        end else if (stub) begin
          target_o = TGT_DROP;
        end else begin
          phys     = own_phys;
          target_o = TGT_MEM;
          dout_o   = wr_data_i;
        end
      end
      default: begin
        phys     = '0;
        target_o = TGT_NONE;
      end
    endcase
  end

  assign phys_o = phys[OUT_BITS-1:0];

endmodule

// ===== src/map_and_bank_address_mapper.sv =====
// MAP/bank address mapper. Takes one request per clock (start_i while busy_o is
// low; busy_o never rises) and returns one result per request, marked by valid_o
// for exactly one cycle. The receiver cannot hold results off, so the block never
// stalls: each request passes the input register (which also captures the
// bank-base memory reads) and then the result register. No clearing pass after
// reset: bank bases carry valid flops.
module map_and_bank_address_mapper
  import mbam_pkg::*;
#(
  parameter int PHYS_BITS   = PHYS_BITS_DEF,
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request side
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [2:0]             op_i,
  input  logic [ADDR_BITS-1:0]   cpu_addr_i,
  input  logic [7:0]             wr_data_i,
  input  logic [7:0]             reg_a_i,
  input  logic [7:0]             reg_x_i,
  input  logic [7:0]             reg_y_i,
  input  logic [7:0]             reg_z_i,
  input  logic [2:0]             block_sel_i,
  input  logic [OUT_BITS-1:0]    bank_phys_i,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_idx_i,
  input  logic [OUT_BITS-1:0]    cfg_data_i,
  // result side
  output logic                   valid_o,
  output logic [OUT_BITS-1:0]    phys_addr_o,
  output logic [1:0]             target_o,
  output logic [7:0]             data_out_o,
  output logic                   irq_inhibit_o,
  output logic [BLOCK_COUNT-1:0] bank_enable_mask_o,
  output logic [OUT_BITS-1:0]    bank_base_out_o
);

  localparam int BLK_BITS = $clog2(BLOCK_COUNT);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [16:0]         rom_start_q;
  logic [OUT_BITS-1:0] rom_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_start_q <= ROM_START_RST;
      rom_base_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROM_START: rom_start_q <= cfg_data_i[16:0];
        CFG_ROM_BASE:  rom_base_q  <= cfg_data_i;
        default:       rom_start_q <= rom_start_q;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register plus registered reads of the bank-base memory
  // ---------------------------------------------------------------------------
  logic                 accept;
  logic                 s1_valid_q;
  logic [2:0]           s1_op_q;
  logic [ADDR_BITS-1:0] s1_addr_q;
  logic [7:0]           s1_wr_data_q, s1_a_q, s1_x_q, s1_y_q, s1_z_q;
  logic [BLK_BITS-1:0]  s1_sel_q;
  logic [OUT_BITS-1:0]  s1_bp_q;

  logic [PHYS_BITS-1:0] bank_mem [BLOCK_COUNT];
  logic [PHYS_BITS-1:0] rd_blk_q, rd_sel_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q      <= op_i;
      s1_addr_q    <= cpu_addr_i;
      s1_wr_data_q <= wr_data_i;
      s1_a_q       <= reg_a_i;
      s1_x_q       <= reg_x_i;
      s1_y_q       <= reg_y_i;
      s1_z_q       <= reg_z_i;
      s1_sel_q     <= block_sel_i[BLK_BITS-1:0];
      s1_bp_q      <= bank_phys_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Mapper state, updated when the request in stage 1 commits
  // ---------------------------------------------------------------------------
  map_state_t           map_q, map_d;
  logic [BLOCK_COUNT-1:0] bank_en_q, bank_en_d;
  logic [BLOCK_COUNT-1:0] base_vld_q, base_vld_d;
  logic                 inhibit_q, inhibit_d;
  logic                 mem_we;
  logic [CALC_BITS-1:0] wr_calc;
  logic [PHYS_BITS-1:0] wr_base;

  assign mem_we  = s1_valid_q && (s1_op_q == OP_BANK_SET || s1_op_q == OP_BANK_BASE);
  assign wr_calc = CALC_BITS'(s1_bp_q);
  assign wr_base = wr_calc[PHYS_BITS-1:0];

  // memory: two read ports at accept, one write port at commit
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_blk_q <= bank_mem[cpu_addr_i[ADDR_BITS-1 -: BLK_BITS]];
      rd_sel_q <= bank_mem[block_sel_i[BLK_BITS-1:0]];
    end
    if (mem_we) begin
      bank_mem[s1_sel_q] <= wr_base;
    end
  end

  // the write committed at the same edge as a read is missed by that read;
  // hold it in a forwarding register so the request that made that read sees it
  logic                 fw_valid_q;
  logic [BLK_BITS-1:0]  fw_idx_q;
  logic [PHYS_BITS-1:0] fw_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_valid_q <= 1'b0;
    end else begin
      fw_valid_q <= mem_we;
    end
  end

  always_ff @(posedge clk_i) begin
    fw_idx_q  <= s1_sel_q;
    fw_data_q <= wr_base;
  end

  logic [BLK_BITS-1:0]  s1_blk;
  logic [PHYS_BITS-1:0] blk_base, sel_base_old, sel_base_new;
  logic [CALC_BITS-1:0] bout_calc;

  assign s1_blk       = s1_addr_q[ADDR_BITS-1 -: BLK_BITS];
  assign blk_base     = (fw_valid_q && fw_idx_q == s1_blk) ? fw_data_q : rd_blk_q;
  assign sel_base_old = (fw_valid_q && fw_idx_q == s1_sel_q) ? fw_data_q : rd_sel_q;
  assign sel_base_new = mem_we ? wr_base : sel_base_old;

  always_comb begin
    map_d      = map_q;
    bank_en_d  = bank_en_q;
    base_vld_d = base_vld_q;
    inhibit_d  = inhibit_q;
    if (s1_valid_q) begin
      case (s1_op_q)
        OP_MAP: begin
          inhibit_d = 1'b1;
          // X = 0F / Z = 0F only reload the megabyte select of that half
          if (s1_x_q == MAP_MB_KEY) begin
            map_d.low_mb = s1_a_q;
          end else begin
            map_d.low_off       = {s1_x_q[3:0], s1_a_q};
            map_d.blk_mask[3:0] = s1_x_q[7:4];
          end
          if (s1_z_q == MAP_MB_KEY) begin
            map_d.high_mb = s1_y_q;
          end else begin
            map_d.high_off      = {s1_z_q[3:0], s1_y_q};
            map_d.blk_mask[7:4] = s1_z_q[7:4];
          end
          bank_en_d  = '0;
          base_vld_d = '0;
        end
        OP_EOM: begin
          inhibit_d = 1'b0;
        end
        OP_BANK_SET: begin
          bank_en_d[s1_sel_q]  = 1'b1;
          base_vld_d[s1_sel_q] = 1'b1;
        end
        OP_BANK_OFF: begin
          bank_en_d[s1_sel_q] = 1'b0;
        end
        OP_BANK_BASE: begin
          base_vld_d[s1_sel_q] = 1'b1;
        end
        default: begin
          inhibit_d = inhibit_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q      <= '0;
      bank_en_q  <= '0;
      base_vld_q <= '0;
      inhibit_q  <= 1'b0;
    end else begin
      map_q      <= map_d;
      bank_en_q  <= bank_en_d;
      base_vld_q <= base_vld_d;
      inhibit_q  <= inhibit_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Translation (uses state before this request) and result register
  // ---------------------------------------------------------------------------
  logic [OUT_BITS-1:0] x_phys;
  logic [1:0]          x_target;
  logic [7:0]          x_dout;

  mbam_xlate #(
    .PHYS_BITS   (PHYS_BITS),
    .BLOCK_COUNT (BLOCK_COUNT)
  ) u_xlate (
    .op_i        (s1_op_q),
    .addr_i      (s1_addr_q),
    .wr_data_i   (s1_wr_data_q),
    .map_st_i    (map_q),
    .bank_en_i   (bank_en_q),
    .blk_base_i  (blk_base),
    .rom_start_i (rom_start_q),
    .rom_base_i  (rom_base_q),
    .phys_o      (x_phys),
    .target_o    (x_target),
    .dout_o      (x_dout)
  );

  // selected bank base as it stands after this request; unset reads as zero
  assign bout_calc = base_vld_d[s1_sel_q] ? CALC_BITS'(sel_base_new) : '0;

  logic                   valid_q;
  logic [OUT_BITS-1:0]    phys_q, bout_q;
  logic [1:0]             target_q;
  logic [7:0]             dout_q;
  logic                   irq_q;
  logic [BLOCK_COUNT-1:0] emask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      phys_q   <= x_phys;
      target_q <= x_target;
      dout_q   <= x_dout;
      irq_q    <= inhibit_d;
      emask_q  <= bank_en_d;
      bout_q   <= bout_calc[OUT_BITS-1:0];
    end
  end

  assign valid_o            = valid_q;
  assign phys_addr_o        = phys_q;
  assign target_o           = target_q;
  assign data_out_o         = dout_q;
  assign irq_inhibit_o      = irq_q;
  assign bank_enable_mask_o = emask_q;
  assign bank_base_out_o    = bout_q;

endmodule
